// ----- rtl/chsm_pkg.sv -----
package chsm_pkg;

  // Bucket count must be a power of two; the bucket index is the low bits of |key|.
  localparam int unsigned BUCKETS    = 8;
  localparam int unsigned POOL_NODES = 256;

  localparam int unsigned BKT_W  = $clog2(BUCKETS);
  localparam int unsigned NODE_W = $clog2(POOL_NODES);
  localparam int unsigned LINK_W = NODE_W + 1;   // node index plus null code
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CNT_W  = $clog2(POOL_NODES + 1);

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_NODES);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_HEAD,
    ST_WALK,
    ST_APPLY,
    ST_LINK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              pop;
    logic              push;
    logic [NODE_W-1:0] push_idx;
  } pool_ctrl_t;

  typedef struct packed {
    logic              empty;
    logic [NODE_W-1:0] idx;
    logic [LINK_W-1:0] free_cnt;
  } pool_stat_t;

  // k may stand before b in chain order (non-strict)
  function automatic logic precedes(input logic desc, input logic signed [KEY_W-1:0] k,
                                    input logic signed [KEY_W-1:0] b);
    precedes = desc ? (k >= b) : (k <= b);
  endfunction

endpackage

// ----- rtl/chsm_ram.sv -----
module chsm_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/chsm_pool.sv -----
module chsm_pool (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  chsm_pkg::pool_ctrl_t ctrl_i,
  output chsm_pkg::pool_stat_t stat_o
);

  // never-used nodes come from a down counter; returned nodes go on a stack
  logic [chsm_pkg::LINK_W-1:0] top_q, top_d;
  logic [chsm_pkg::LINK_W-1:0] fresh_q, fresh_d;
  logic [chsm_pkg::NODE_W-1:0] stk_rd;
  logic [chsm_pkg::LINK_W-1:0] top_m1, fresh_m1;

  assign top_m1   = top_q - 1'b1;
  assign fresh_m1 = fresh_q - 1'b1;

  chsm_ram #(
    .DEPTH(chsm_pkg::POOL_NODES),
    .WIDTH(chsm_pkg::NODE_W)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.push),
    .waddr_i(top_q[chsm_pkg::NODE_W-1:0]),
    .wdata_i(ctrl_i.push_idx),
    .raddr_i(top_m1[chsm_pkg::NODE_W-1:0]),
    .rdata_o(stk_rd)
  );

  always_comb begin
    top_d   = top_q;
    fresh_d = fresh_q;
    if (ctrl_i.push) begin
      top_d = top_q + 1'b1;
    end else if (ctrl_i.pop) begin
      if (top_q != '0) begin
        top_d = top_m1;
      end else begin
        fresh_d = fresh_m1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= '0;
      fresh_q <= chsm_pkg::LINK_W'(chsm_pkg::POOL_NODES);
    end else begin
      top_q   <= top_d;
      fresh_q <= fresh_d;
    end
  end

  assign stat_o.empty    = (top_q == '0) && (fresh_q == '0);
  assign stat_o.idx      = (top_q != '0) ? stk_rd : fresh_m1[chsm_pkg::NODE_W-1:0];
  assign stat_o.free_cnt = top_q + fresh_q;

endmodule

// ----- rtl/chained_hash_sorted_map.sv -----
// Sequence: LOOK, then HEAD when the head node is read (bucket not empty, op code used),
//   then one WALK step per chain node visited past the head, then APPLY, then LINK when
//   an insert adds a new node, then DONE, which registers the result beat.
// Flow: one operation at a time; ready again right after the result is registered,
//   which waits while an earlier result beat is still unaccepted (one node RAM read port).
// Reset (async, active low): empty buckets, zero entries, all nodes free,
//   ascending order; node storage is not cleared and needs no clearing pass.
module chained_hash_sorted_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // order_descending
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // result_value[31:0], entry_total[40:32], zero pad
  output logic [1:0]  m_axis_tuser    // found[0], pool_full[1]
);

  localparam int unsigned NW = chsm_pkg::NODE_W;
  localparam int unsigned LW = chsm_pkg::LINK_W;
  localparam int unsigned KW = chsm_pkg::KEY_W;
  localparam int unsigned VW = chsm_pkg::VAL_W;
  localparam int unsigned CW = chsm_pkg::CNT_W;
  localparam int unsigned BW = chsm_pkg::BKT_W;

  chsm_pkg::state_e state_q, state_d;

  // operation registers
  chsm_pkg::op_e          op_q;
  logic signed [KW-1:0]   key_q;
  logic signed [VW-1:0]   val_q;
  logic [BW-1:0]          bkt_q;
  logic [LW-1:0]          h_q, h_d;

  // walk registers
  logic [NW-1:0]        cur_q, cur_d, prev_q, prev_d;
  logic signed [KW-1:0] cur_key_q, cur_key_d;
  logic signed [VW-1:0] cur_val_q, cur_val_d;
  logic [LW-1:0]        nx_q, nx_d;

  // outcome
  logic                 found_q, found_d, head_hit_q, head_hit_d, full_q, full_d;
  logic signed [VW-1:0] res_q, res_d;
  logic [NW-1:0]        hit_q, hit_d, new_q, new_d;
  logic [LW-1:0]        pred_q, pred_d, pred_link_q, pred_link_d, hit_link_q, hit_link_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          desc_q;
  logic [LW-1:0] head_q [chsm_pkg::BUCKETS];
  logic          head_we;
  logic [LW-1:0] head_wd;

  // output stage
  logic                 ovalid_q, ofound_q, ofull_q;
  logic signed [VW-1:0] ores_q;
  logic [CW-1:0]        ocnt_q;
  logic                 out_load;

  // node RAMs share one read address
  logic [NW-1:0]        raddr;
  logic signed [KW-1:0] rkey;
  logic signed [VW-1:0] rval;
  logic [LW-1:0]        rlink;
  logic                 key_we, val_we, link_we;
  logic [NW-1:0]        key_wa, val_wa, link_wa;
  logic [VW-1:0]        val_wd;
  logic [LW-1:0]        link_wd;

  chsm_pkg::pool_ctrl_t pool_ctrl;
  chsm_pkg::pool_stat_t pool_stat;

  logic                 in_acc;
  logic signed [KW-1:0] in_key, in_mag;
  logic                 eq_rd, eq_cur, prec_rd, rlink_nil;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_key  = s_axis_tdata[KW-1:0];
  assign in_mag  = in_key[KW-1] ? -in_key : in_key;   // most negative key wraps to 2^31

  // shared compare unit on the node just read and on the current walk node
  assign eq_rd     = (rkey == key_q);
  assign eq_cur    = (cur_key_q == key_q);
  assign prec_rd   = chsm_pkg::precedes(desc_q, key_q, rkey);
  assign rlink_nil = (rlink == chsm_pkg::NIL_LINK);

  chsm_ram #(.DEPTH(chsm_pkg::POOL_NODES), .WIDTH(KW)) u_key (
    .clk_i(clk_i), .we_i(key_we), .waddr_i(key_wa), .wdata_i(key_q),
    .raddr_i(raddr), .rdata_o(rkey)
  );
  chsm_ram #(.DEPTH(chsm_pkg::POOL_NODES), .WIDTH(VW)) u_val (
    .clk_i(clk_i), .we_i(val_we), .waddr_i(val_wa), .wdata_i(val_wd),
    .raddr_i(raddr), .rdata_o(rval)
  );
  chsm_ram #(.DEPTH(chsm_pkg::POOL_NODES), .WIDTH(LW)) u_link (
    .clk_i(clk_i), .we_i(link_we), .waddr_i(link_wa), .wdata_i(link_wd),
    .raddr_i(raddr), .rdata_o(rlink)
  );

  chsm_pool u_pool (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(pool_ctrl),
    .stat_o(pool_stat)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chsm_pkg::ST_IDLE: begin
        if (in_acc) state_d = chsm_pkg::ST_LOOK;
      end
      chsm_pkg::ST_LOOK: begin
        if (op_q == chsm_pkg::OP_NONE || head_q[bkt_q] == chsm_pkg::NIL_LINK) begin
          state_d = chsm_pkg::ST_APPLY;
        end else begin
          state_d = chsm_pkg::ST_HEAD;
        end
      end
      chsm_pkg::ST_HEAD: begin
        if (eq_rd || (op_q == chsm_pkg::OP_ADD && prec_rd) || rlink_nil) begin
          state_d = chsm_pkg::ST_APPLY;
        end else begin
          state_d = chsm_pkg::ST_WALK;
        end
      end
      chsm_pkg::ST_WALK: begin
        if (prec_rd || rlink_nil) state_d = chsm_pkg::ST_APPLY;
      end
      chsm_pkg::ST_APPLY: begin
        if (op_q == chsm_pkg::OP_ADD && !found_q && !pool_stat.empty) begin
          state_d = chsm_pkg::ST_LINK;
        end else begin
          state_d = chsm_pkg::ST_DONE;
        end
      end
      chsm_pkg::ST_LINK: state_d = chsm_pkg::ST_DONE;
      chsm_pkg::ST_DONE: begin
        if (!ovalid_q || m_axis_tready) state_d = chsm_pkg::ST_IDLE;
      end
      default: state_d = chsm_pkg::ST_IDLE;
    endcase
  end

  // datapath and strobes
  always_comb begin
    h_d         = h_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    cur_key_d   = cur_key_q;
    cur_val_d   = cur_val_q;
    nx_d        = nx_q;
    found_d     = found_q;
    head_hit_d  = head_hit_q;
    full_d      = full_q;
    res_d       = res_q;
    hit_d       = hit_q;
    new_d       = new_q;
    pred_d      = pred_q;
    pred_link_d = pred_link_q;
    hit_link_d  = hit_link_q;
    cnt_d       = cnt_q;
    raddr       = nx_q[NW-1:0];
    key_we      = 1'b0;
    val_we      = 1'b0;
    link_we     = 1'b0;
    key_wa      = pool_stat.idx;
    val_wa      = pool_stat.idx;
    val_wd      = val_q;
    link_wa     = pool_stat.idx;
    link_wd     = pred_link_q;
    head_we     = 1'b0;
    head_wd     = hit_link_q;
    pool_ctrl   = '0;
    out_load    = 1'b0;
    unique case (state_q)
      chsm_pkg::ST_LOOK: begin
        h_d         = head_q[bkt_q];
        raddr       = head_q[bkt_q][NW-1:0];
        found_d     = 1'b0;
        head_hit_d  = 1'b0;
        full_d      = 1'b0;
        res_d       = '0;
        pred_d      = chsm_pkg::NIL_LINK;
        pred_link_d = head_q[bkt_q];
      end
      chsm_pkg::ST_HEAD: begin
        raddr = rlink[NW-1:0];
        if (eq_rd) begin
          found_d    = 1'b1;
          head_hit_d = 1'b1;
          res_d      = rval;
          hit_d      = h_q[NW-1:0];
          hit_link_d = rlink;
        end else if (!(op_q == chsm_pkg::OP_ADD && prec_rd)) begin
          cur_d     = h_q[NW-1:0];
          prev_d    = h_q[NW-1:0];
          cur_key_d = rkey;
          cur_val_d = rval;
          nx_d      = rlink;
          if (rlink_nil) begin
            pred_d      = h_q;
            pred_link_d = chsm_pkg::NIL_LINK;
          end
        end
      end
      chsm_pkg::ST_WALK: begin
        raddr = rlink[NW-1:0];
        if (!prec_rd) begin
          if (rlink_nil) begin
            if (eq_rd) begin
              found_d    = 1'b1;
              res_d      = rval;
              hit_d      = nx_q[NW-1:0];
              pred_d     = {1'b0, cur_q};
              hit_link_d = rlink;
            end else begin
              pred_d      = nx_q;
              pred_link_d = chsm_pkg::NIL_LINK;
            end
          end else begin
            prev_d    = cur_q;
            cur_d     = nx_q[NW-1:0];
            cur_key_d = rkey;
            cur_val_d = rval;
            nx_d      = rlink;
          end
        end else if (eq_cur) begin
          found_d    = 1'b1;
          res_d      = cur_val_q;
          hit_d      = cur_q;
          pred_d     = {1'b0, prev_q};
          hit_link_d = nx_q;
        end else if (eq_rd) begin
          found_d    = 1'b1;
          res_d      = rval;
          hit_d      = nx_q[NW-1:0];
          pred_d     = {1'b0, cur_q};
          hit_link_d = rlink;
        end else begin
          pred_d      = {1'b0, cur_q};
          pred_link_d = nx_q;
        end
      end
      chsm_pkg::ST_APPLY: begin
        unique case (op_q)
          chsm_pkg::OP_ADD: begin
            if (found_q) begin
              val_we = 1'b1;
              val_wa = hit_q;
            end else if (pool_stat.empty) begin
              full_d = 1'b1;
            end else begin
              key_we        = 1'b1;
              val_we        = 1'b1;
              link_we       = 1'b1;
              new_d         = pool_stat.idx;
              pool_ctrl.pop = 1'b1;
              cnt_d         = cnt_q + 1'b1;
            end
          end
          chsm_pkg::OP_REMOVE: begin
            if (found_q) begin
              if (head_hit_q) begin
                head_we = 1'b1;
              end else begin
                link_we = 1'b1;
                link_wa = pred_q[NW-1:0];
                link_wd = hit_link_q;
              end
              pool_ctrl.push     = 1'b1;
              pool_ctrl.push_idx = hit_q;
              cnt_d              = cnt_q - 1'b1;
            end
          end
          chsm_pkg::OP_SEARCH, chsm_pkg::OP_NONE: begin
          end
          default: begin
          end
        endcase
      end
      chsm_pkg::ST_LINK: begin
        // splice the new node in after its predecessor or at the head
        if (pred_q == chsm_pkg::NIL_LINK) begin
          head_we = 1'b1;
          head_wd = {1'b0, new_q};
        end else begin
          link_we = 1'b1;
          link_wa = pred_q[NW-1:0];
          link_wd = {1'b0, new_q};
        end
      end
      chsm_pkg::ST_DONE: begin
        out_load = !ovalid_q || m_axis_tready;
      end
      chsm_pkg::ST_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chsm_pkg::ST_IDLE;
      cnt_q   <= '0;
      desc_q  <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < int'(chsm_pkg::BUCKETS); i++) begin
        head_q[i] <= chsm_pkg::NIL_LINK;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) desc_q <= cfg_wdata_i;
      if (head_we) head_q[bkt_q] <= head_wd;
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= chsm_pkg::op_e'(s_axis_tuser);
      key_q <= in_key;
      val_q <= s_axis_tdata[KW+VW-1:KW];
      bkt_q <= in_mag[BW-1:0];
    end
    h_q         <= h_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    cur_key_q   <= cur_key_d;
    cur_val_q   <= cur_val_d;
    nx_q        <= nx_d;
    found_q     <= found_d;
    head_hit_q  <= head_hit_d;
    full_q      <= full_d;
    res_q       <= res_d;
    hit_q       <= hit_d;
    new_q       <= new_d;
    pred_q      <= pred_d;
    pred_link_q <= pred_link_d;
    hit_link_q  <= hit_link_d;
    if (out_load) begin
      ofound_q <= found_q;
      ofull_q  <= full_q;
      ores_q   <= res_q;
      ocnt_q   <= cnt_q;
    end
  end

  assign s_axis_tready = (state_q == chsm_pkg::ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'b0, ocnt_q, ores_q};
  assign m_axis_tuser  = {ofull_q, ofound_q};

  // every node is either linked (counted) or free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} + {1'b0, pool_stat.free_cnt}) == (CW + 1)'(chsm_pkg::POOL_NODES))
    else $error("node accounting lost a node");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("found and pool_full both set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chsm_pkg::ST_APPLY && pool_ctrl.pop) |-> !pool_stat.empty)
    else $error("allocation from an empty pool");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("result beat dropped");

endmodule
